// File: design/prcm_pkg.sv
// Package for the RC pulse to rotor command mapper.
// Shared widths, status and register codes, lane and control structs, and the
// elaboration-time functions that fill the per-lane lookup ROMs. No dependencies.
package prcm_pkg;

  localparam int unsigned D_W      = 10;   // clamped pulse offset, 0..1000
  localparam int unsigned VEL_W    = 15;
  localparam int unsigned AMP_W    = 14;
  localparam int unsigned PH_W     = 16;
  localparam int unsigned THRESH_W = 12;
  localparam int unsigned COUNT_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ROM_DEPTH = 1001;

  localparam int unsigned PULSE_MIN  = 1000;
  localparam int unsigned PULSE_SPAN = 1000;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd970;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 2'd2;
  localparam logic [COUNT_W-1:0]  COUNT_ONE    = 2'd1;
  localparam logic [COUNT_W-1:0]  COUNT_TWO    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DISARM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTORS = 2'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DISARMED  = 2'd1,
    ST_BAD_COUNT = 2'd2
  } status_t;

  typedef struct packed {
    logic [VEL_W-1:0] vel;
    logic [AMP_W-1:0] amp;
    logic [PH_W-1:0]  phase;
  } lane_res_t;

  typedef struct packed {
    logic               disarmed;
    logic [COUNT_W-1:0] count;
  } ctrl_t;

  // ROM fill arithmetic, evaluated at elaboration only
  localparam logic [63:0] LOG_DEN    = 64'd10000;
  localparam logic [63:0] TWO_Q30    = 64'd1 << 31;
  localparam logic [63:0] PI_Q40     = 64'h3243F6A8886;
  localparam logic [63:0] PHASE_DEN  = 64'd1000 << 28;
  localparam logic [63:0] AMP_DEN    = 64'd77526;
  localparam logic [63:0] VEL_MAX_Q8 = 64'd23040;
  localparam logic [63:0] AMP_MAX    = 64'd13107;

  // log2(num / 10000) in Q32 by repeated squaring of a Q30 mantissa
  function automatic logic [63:0] log2_q32(input logic [63:0] num);
    logic [63:0] m;
    logic [63:0] r;
    m = (num << 30) / LOG_DEN;
    r = 64'd0;
    for (int k = 0; k < 8; k++) begin
      if (m >= TWO_Q30) begin
        m = m >> 1;
        r = r + (64'd1 << 32);
      end
    end
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= TWO_Q30) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [63:0] LA_Q32 = log2_q32(64'd10270);

  function automatic logic [63:0] vel_of_x(input logic [63:0] x);
    logic [63:0] lv;
    lv = log2_q32(x);
    return (lv * 64'd256 + LA_Q32 / 2) / LA_Q32;
  endfunction

  localparam logic [63:0] VEL_LO = vel_of_x(64'd12980);

  function automatic logic [VEL_W-1:0] velocity_q8(input logic [63:0] d);
    logic [63:0] v;
    v = vel_of_x(64'd12980 + 64'd79 * d);
    if (v < VEL_LO) v = VEL_LO;
    if (v > VEL_MAX_Q8) v = VEL_MAX_Q8;
    return v[VEL_W-1:0];
  endfunction

  function automatic logic [AMP_W-1:0] amplitude_q16(input logic [63:0] d);
    logic [63:0] a;
    a = (d * 64'd983040 + 64'd38763) / AMP_DEN;
    if (a > AMP_MAX) a = AMP_MAX;
    return a[AMP_W-1:0];
  endfunction

  // ties round away from zero
  function automatic logic [PH_W-1:0] phase_q12(input logic [63:0] d);
    logic [63:0] n2;
    logic [63:0] mag;
    logic [63:0] q;
    logic        neg;
    n2  = 64'd2 * d;
    neg = (n2 < 64'd1500);
    mag = neg ? (64'd1500 - n2) : (n2 - 64'd1500);
    q   = (mag * PI_Q40 + PHASE_DEN / 2) / PHASE_DEN;
    if (neg) q = 64'd0 - q;
    return q[PH_W-1:0];
  endfunction

endpackage

// File: design/pwm_to_rotor_command_mapper_unit.sv
// Top level of the RC pulse to rotor command mapper.
// Holds the config registers and the two-stage handshake control; instantiates
// two prcm_lane copies and prcm_merge. Depends on prcm_pkg.
//
// Usage:
//   cfg channel: cfg_index 0 writes disarm_threshold (cfg_data[11:0]), 1 writes
//   motor_count (cfg_data[1:0]); other indexes are dropped. cfg_ready is
//   always high.
//   in channel: six pulse widths per item, taken when in_valid && in_ready.
//   out channel: one result item per input item, in order.
// Path: an accepted item is held in the lane ROM read register, then in the
//   merge output register, from which it can be taken.
// Throughput: one item per cycle; both stages advance on every edge at which
//   the output register is empty or being taken.
// Reset: both pipeline stages empty, disarm_threshold = 970, motor_count = 2.
// Stall: with out_ready low the output register holds; the lane stage still
//   fills, and in_ready drops once both stages hold an item.
module pwm_to_rotor_command_mapper_unit #(
  parameter int unsigned PULSE_WIDTH_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [prcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prcm_pkg::THRESH_W-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PULSE_WIDTH_BITS-1:0]         thrust_pulse_a,
  input  logic [PULSE_WIDTH_BITS-1:0]         thrust_pulse_b,
  input  logic [PULSE_WIDTH_BITS-1:0]         elevation_pulse_a,
  input  logic [PULSE_WIDTH_BITS-1:0]         elevation_pulse_b,
  input  logic [PULSE_WIDTH_BITS-1:0]         azimuth_pulse_a,
  input  logic [PULSE_WIDTH_BITS-1:0]         azimuth_pulse_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic [prcm_pkg::COUNT_W-1:0]        motors_driven,
  output logic [prcm_pkg::VEL_W-1:0]          velocity_a,
  output logic [prcm_pkg::AMP_W-1:0]          ampl_a,
  output logic signed [prcm_pkg::PH_W-1:0]    phase_a,
  output logic [prcm_pkg::VEL_W-1:0]          velocity_b,
  output logic [prcm_pkg::AMP_W-1:0]          ampl_b,
  output logic signed [prcm_pkg::PH_W-1:0]    phase_b
);
  import prcm_pkg::*;

  localparam int unsigned CMP_W =
    (PULSE_WIDTH_BITS > THRESH_W) ? PULSE_WIDTH_BITS : THRESH_W;

  logic [THRESH_W-1:0] disarm_threshold;
  logic [COUNT_W-1:0]  motor_count;

  logic      lane_valid;
  logic      out_full;
  logic      en_lane;
  logic      en_out;
  logic      disarm_now;
  ctrl_t     ctrl;
  lane_res_t res_a;
  lane_res_t res_b;
  lane_res_t out_a;
  lane_res_t out_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      disarm_threshold <= THRESH_RESET;
      motor_count      <= COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DISARM: disarm_threshold <= cfg_data;
        REG_MOTORS: motor_count      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: output register frees on take, lane stage moves when it can
  assign en_out   = !out_full || out_ready;
  assign en_lane  = !lane_valid || en_out;
  assign in_ready = en_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
      out_full   <= 1'b0;
    end else begin
      if (en_lane) lane_valid <= in_valid;
      if (en_out)  out_full   <= lane_valid;
    end
  end

  assign disarm_now =
    (CMP_W'(thrust_pulse_a) < CMP_W'(disarm_threshold)) ||
    (CMP_W'(thrust_pulse_b) < CMP_W'(disarm_threshold));

  always_ff @(posedge clk) begin
    if (en_lane) begin
      ctrl.disarmed <= disarm_now;
      ctrl.count    <= motor_count;
    end
  end

  prcm_lane #(.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)) u_lane_a (
    .clk             (clk),
    .en              (en_lane),
    .thrust_pulse    (thrust_pulse_a),
    .elevation_pulse (elevation_pulse_a),
    .azimuth_pulse   (azimuth_pulse_a),
    .res             (res_a)
  );

  prcm_lane #(.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)) u_lane_b (
    .clk             (clk),
    .en              (en_lane),
    .thrust_pulse    (thrust_pulse_b),
    .elevation_pulse (elevation_pulse_b),
    .azimuth_pulse   (azimuth_pulse_b),
    .res             (res_b)
  );

  prcm_merge u_merge (
    .clk           (clk),
    .en            (en_out),
    .ctrl          (ctrl),
    .res_a         (res_a),
    .res_b         (res_b),
    .status        (status),
    .motors_driven (motors_driven),
    .out_a         (out_a),
    .out_b         (out_b)
  );

  assign out_valid  = out_full;
  assign velocity_a = out_a.vel;
  assign ampl_a     = out_a.amp;
  assign phase_a    = $signed(out_a.phase);
  assign velocity_b = out_b.vel;
  assign ampl_b     = out_b.amp;
  assign phase_b    = $signed(out_b.phase);

endmodule

// File: design/prcm_lane.sv
// One rotor lane: clamps the three pulses to an offset and reads the
// velocity, amplitude and phase ROMs (registered read). Depends on prcm_pkg.
module prcm_lane #(
  parameter int unsigned PULSE_WIDTH_BITS = 12
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [PULSE_WIDTH_BITS-1:0]       thrust_pulse,
  input  logic [PULSE_WIDTH_BITS-1:0]       elevation_pulse,
  input  logic [PULSE_WIDTH_BITS-1:0]       azimuth_pulse,
  output prcm_pkg::lane_res_t               res
);
  import prcm_pkg::*;

  localparam logic [PULSE_WIDTH_BITS-1:0] P_LO = PULSE_WIDTH_BITS'(PULSE_MIN);
  localparam logic [PULSE_WIDTH_BITS-1:0] P_HI =
    PULSE_WIDTH_BITS'(PULSE_MIN + PULSE_SPAN);

  logic [VEL_W-1:0] vel_rom [ROM_DEPTH];
  logic [AMP_W-1:0] amp_rom [ROM_DEPTH];
  logic [PH_W-1:0]  ph_rom  [ROM_DEPTH];

  logic [D_W-1:0] d_thrust;
  logic [D_W-1:0] d_elev;
  logic [D_W-1:0] d_azim;

  function automatic logic [D_W-1:0] clamp_off(input logic [PULSE_WIDTH_BITS-1:0] p);
    logic [PULSE_WIDTH_BITS-1:0] diff;
    diff = p - P_LO;
    if (p < P_LO) return '0;
    if (p > P_HI) return D_W'(PULSE_SPAN);
    return diff[D_W-1:0];
  endfunction

  // constant contents, folded at elaboration
  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    assign vel_rom[g] = velocity_q8(64'(g));
    assign amp_rom[g] = amplitude_q16(64'(g));
    assign ph_rom[g]  = phase_q12(64'(g));
  end

  assign d_thrust = clamp_off(thrust_pulse);
  assign d_elev   = clamp_off(elevation_pulse);
  assign d_azim   = clamp_off(azimuth_pulse);

  always_ff @(posedge clk) begin
    if (en) begin
      res.vel   <= vel_rom[d_thrust];
      res.amp   <= amp_rom[d_elev];
      res.phase <= ph_rom[d_azim];
    end
  end

endmodule

// File: design/prcm_merge.sv
// Merge stage: combines both lane results with the armed state and motor
// count into status, motors_driven and gated fields. Depends on prcm_pkg.
module prcm_merge (
  input  logic                         clk,
  input  logic                         en,
  input  prcm_pkg::ctrl_t              ctrl,
  input  prcm_pkg::lane_res_t          res_a,
  input  prcm_pkg::lane_res_t          res_b,
  output logic [1:0]                   status,
  output logic [prcm_pkg::COUNT_W-1:0] motors_driven,
  output prcm_pkg::lane_res_t          out_a,
  output prcm_pkg::lane_res_t          out_b
);
  import prcm_pkg::*;

  logic               count_ok;
  status_t            status_next;
  logic [COUNT_W-1:0] motors_next;
  lane_res_t          out_a_next;
  lane_res_t          out_b_next;

  assign count_ok = (ctrl.count == COUNT_ONE) || (ctrl.count == COUNT_TWO);

  always_comb begin
    out_a_next = '0;
    out_b_next = '0;
    if (ctrl.disarmed) begin
      status_next = ST_DISARMED;
      motors_next = count_ok ? ctrl.count : '0;
    end else if (!count_ok) begin
      status_next = ST_BAD_COUNT;
      motors_next = '0;
    end else begin
      status_next = ST_OK;
      motors_next = ctrl.count;
      out_a_next  = res_a;
      if (ctrl.count == COUNT_TWO) out_b_next = res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status        <= status_next;
      motors_driven <= motors_next;
      out_a         <= out_a_next;
      out_b         <= out_b_next;
    end
  end

endmodule
